// ----- sv/lsbse_pkg.sv -----
package lsbse_pkg;

    // header length in carriers, legal range 8 to 32
    localparam int unsigned HEADER_BITS = 32;
    localparam int unsigned HDR_IW      = $clog2(HEADER_BITS);

    localparam int unsigned POS_W   = 33;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned MSGB_W  = 29;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned CFG_IW  = 2;
    localparam int unsigned CFG_DW  = 32;

    typedef logic [CFG_IW-1:0] t_cfg_index;

    localparam t_cfg_index CFG_MODE          = 2'd0;
    localparam t_cfg_index CFG_MESSAGE_BYTES = 2'd1;
    localparam t_cfg_index CFG_CARRIER_COUNT = 2'd2;

    localparam logic MODE_EMBED   = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

endpackage

// ----- sv/lsb_stego_embed_extract.sv -----
// LSB steganography over a stream of carrier bytes, one result per carrier.
// In embed mode the first 32 carriers of an image take the message length in
// bits (MSB first) in their LSBs and the following carriers take the message
// bits, MSB first per byte; when the message and header do not fit in
// carrier_count every carrier passes unchanged with error set. In extract
// mode carriers pass unchanged while the length is rebuilt from the header
// and message bytes are emitted with a last mark (a final partial byte is
// right aligned). A carrier with first set restarts the image. The block
// takes one carrier per clock unless the output side stalls: each request
// is handled in the cycle it is accepted and its result sits in a single
// output register, which is refilled in the same cycle it is taken, so a
// result is shown in the cycle after its carrier is accepted.
// Configuration writes are accepted in any cycle and take effect at once.
module lsb_stego_embed_extract (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // carrier input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_first,
    input  logic [7:0]  i_carrier_byte,
    input  logic [7:0]  i_message_byte,
    // result output
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_msg_valid,
    output logic [7:0]  o_msg_byte,
    output logic        o_msg_last,
    output logic        o_length_valid,
    output logic [28:0] o_length_bytes,
    output logic        o_error
);

    localparam int unsigned POS_W  = lsbse_pkg::POS_W;
    localparam int unsigned LEN_W  = lsbse_pkg::LEN_W;
    localparam int unsigned HDR_IW = lsbse_pkg::HDR_IW;
    localparam logic [POS_W-1:0] HB_POS = POS_W'(lsbse_pkg::HEADER_BITS);

    logic                          r_mode;
    logic [lsbse_pkg::MSGB_W-1:0]  r_message_bytes;
    logic [lsbse_pkg::CNT_W-1:0]   r_carrier_count;

    logic [POS_W-1:0] r_pos,  n_pos;
    logic [LEN_W-1:0] r_hlen, n_hlen;
    logic [7:0]       r_acc,  n_acc;

    logic        r_valid;
    logic [7:0]  r_out_byte,     n_out_byte;
    logic        r_msg_valid,    n_msg_valid;
    logic [7:0]  r_msg_byte,     n_msg_byte;
    logic        r_msg_last,     n_msg_last;
    logic        r_length_valid, n_length_valid;
    logic [28:0] r_length_bytes, n_length_bytes;
    logic        r_error,        n_error;

    logic             w_accept;
    logic [POS_W-1:0] w_p;
    logic [POS_W-1:0] w_i;
    logic [LEN_W-1:0] w_lenb;
    logic [LEN_W-1:0] w_len_shift;
    logic [HDR_IW-1:0] w_hdr_idx;
    logic [7:0]       w_msg_shift;
    logic [LEN_W-1:0] w_hl;
    logic [7:0]       w_acc;
    logic             w_lsb;
    logic             w_in_hdr;

    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_valid;
    assign o_ready        = !r_valid || i_ready;
    assign w_accept       = i_valid && o_ready;
    assign o_out_byte     = r_out_byte;
    assign o_msg_valid    = r_msg_valid;
    assign o_msg_byte     = r_msg_byte;
    assign o_msg_last     = r_msg_last;
    assign o_length_valid = r_length_valid;
    assign o_length_bytes = r_length_bytes;
    assign o_error        = r_error;

    always_comb begin
        // first restarts the image before this carrier is handled
        w_p   = i_first ? '0 : r_pos;
        w_hl  = i_first ? '0 : r_hlen;
        w_acc = i_first ? '0 : r_acc;
        w_lsb = i_carrier_byte[0];
        w_in_hdr = w_p < HB_POS;
        w_i   = w_p - HB_POS;

        w_lenb      = {r_message_bytes, 3'b000};
        w_hdr_idx   = HDR_IW'(lsbse_pkg::HEADER_BITS - 1) - w_p[HDR_IW-1:0];
        w_len_shift = w_lenb >> w_hdr_idx;
        w_msg_shift = i_message_byte >> (3'd7 - w_i[2:0]);

        n_hlen         = w_hl;
        n_acc          = w_acc;
        n_out_byte     = i_carrier_byte;
        n_msg_valid    = 1'b0;
        n_msg_byte     = '0;
        n_msg_last     = 1'b0;
        n_length_valid = 1'b0;
        n_length_bytes = '0;
        n_error        = 1'b0;

        if (r_mode == lsbse_pkg::MODE_EMBED) begin
            priority if ({1'b0, w_lenb} + HB_POS > {1'b0, r_carrier_count}) begin
                n_error = 1'b1;
            end else if (w_in_hdr) begin
                n_out_byte = {i_carrier_byte[7:1], w_len_shift[0]};
            end else if (w_i < {1'b0, w_lenb}) begin
                n_out_byte = {i_carrier_byte[7:1], w_msg_shift[0]};
            end
        end else begin
            if (w_in_hdr) begin
                n_hlen = {w_hl[LEN_W-2:0], w_lsb};
            end else if (w_i < {1'b0, w_hl}) begin
                n_acc = {w_acc[6:0], w_lsb};
                // byte complete, or the final bit of the message
                if (w_i[2:0] == 3'd7 || w_i == {1'b0, w_hl} - 1'b1) begin
                    n_msg_valid = 1'b1;
                    n_msg_byte  = n_acc;
                    n_msg_last  = w_i == {1'b0, w_hl} - 1'b1;
                    n_acc       = '0;
                end
            end
            if (w_p >= HB_POS - 1'b1) begin
                n_length_valid = 1'b1;
                n_length_bytes = n_hlen[LEN_W-1:3];
            end
        end

        n_pos = (w_p < lsbse_pkg::POS_MAX) ? w_p + 1'b1 : lsbse_pkg::POS_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= lsbse_pkg::MODE_EMBED;
            r_message_bytes <= '0;
            r_carrier_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lsbse_pkg::CFG_MODE:          r_mode          <= i_cfg_data[0];
                lsbse_pkg::CFG_MESSAGE_BYTES: r_message_bytes <= i_cfg_data[28:0];
                lsbse_pkg::CFG_CARRIER_COUNT: r_carrier_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hlen  <= '0;
            r_acc   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_pos  <= n_pos;
                r_hlen <= n_hlen;
                r_acc  <= n_acc;
            end
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_byte     <= n_out_byte;
            r_msg_valid    <= n_msg_valid;
            r_msg_byte     <= n_msg_byte;
            r_msg_last     <= n_msg_last;
            r_length_valid <= n_length_valid;
            r_length_bytes <= n_length_bytes;
            r_error        <= n_error;
        end
    end

endmodule

// ----- sv/lsbse_checker.sv -----
module lsbse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_in_ready,
    input logic [7:0]  i_out_byte,
    input logic        i_msg_valid,
    input logic [7:0]  i_msg_byte,
    input logic        i_msg_last,
    input logic        i_length_valid,
    input logic [28:0] i_length_bytes,
    input logic        i_error
);

    // an error result never carries extract fields
    a_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error |-> !i_msg_valid && !i_length_valid)
        else $error("error raised together with extract fields");

    a_last_in_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_msg_last |-> i_msg_valid)
        else $error("last mark without a message byte");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_msg_valid || i_msg_byte == 8'd0)
            && (i_length_valid || i_length_bytes == 29'd0))
        else $error("idle message or length field not zero");

    // a stalled result holds the input side off and stays put
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready
            ##1 (i_out_valid && $stable(i_out_byte) && $stable(i_msg_byte)))
        else $error("stalled result changed or input not held off");

endmodule

bind lsb_stego_embed_extract lsbse_checker u_lsbse_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_valid),
    .i_out_ready    (i_ready),
    .i_in_ready     (o_ready),
    .i_out_byte     (o_out_byte),
    .i_msg_valid    (o_msg_valid),
    .i_msg_byte     (o_msg_byte),
    .i_msg_last     (o_msg_last),
    .i_length_valid (o_length_valid),
    .i_length_bytes (o_length_bytes),
    .i_error        (o_error)
);

// ----- tb/sv/tb.sv -----
typedef struct packed {
    logic [7:0]                   out_byte;
    logic                         msg_valid;
    logic [7:0]                   msg_byte;
    logic                         msg_last;
    logic                         length_valid;
    logic [lsbse_pkg::MSGB_W-1:0] length_bytes;
    logic                         error;
} t_stego_result;

class stego_checker;
    logic                         mode;
    logic [lsbse_pkg::MSGB_W-1:0] msg_bytes;
    logic [lsbse_pkg::CNT_W-1:0]  carrier_count;
    logic [lsbse_pkg::POS_W-1:0]  pos;
    logic [lsbse_pkg::LEN_W-1:0]  hdr_len;
    logic [7:0]                   accum;
    t_stego_result                due_q[$];
    int unsigned                  n_carriers;
    int unsigned                  n_embed;
    int unsigned                  n_cap_err;
    int unsigned                  n_msg;
    int unsigned                  n_last;
    int unsigned                  n_mismatch;

    function new();
        mode          = lsbse_pkg::MODE_EMBED;
        msg_bytes     = '0;
        carrier_count = '0;
        pos           = '0;
        hdr_len       = '0;
        accum         = '0;
        n_carriers    = 0;
        n_embed       = 0;
        n_cap_err     = 0;
        n_msg         = 0;
        n_last        = 0;
        n_mismatch    = 0;
    endfunction

    function void write_reg(lsbse_pkg::t_cfg_index idx, logic [lsbse_pkg::CFG_DW-1:0] data);
        case (idx)
            lsbse_pkg::CFG_MODE:          mode = data[0];
            lsbse_pkg::CFG_MESSAGE_BYTES: msg_bytes = data[lsbse_pkg::MSGB_W-1:0];
            lsbse_pkg::CFG_CARRIER_COUNT: carrier_count = data[lsbse_pkg::CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function int unsigned pending();
        return due_q.size();
    endfunction

    // work out the result of one accepted carrier and queue it
    function void note_carrier(logic first, logic [7:0] carrier, logic [7:0] mbyte);
        t_stego_result r;
        logic [63:0]   p;
        logic [63:0]   lenb;
        logic [63:0]   idx;
        logic [63:0]   hl;
        logic [63:0]   hb;
        r = '0;
        r.out_byte = carrier;
        hb = 64'(lsbse_pkg::HEADER_BITS);
        if (first) begin
            pos     = '0;
            hdr_len = '0;
            accum   = '0;
        end
        p = 64'(pos);
        if (mode == lsbse_pkg::MODE_EMBED) begin
            lenb = 64'(msg_bytes) * 64'd8;
            if (lenb + hb > 64'(carrier_count)) begin
                r.error = 1'b1;
            end else if (p < hb) begin
                r.out_byte = {carrier[7:1], lenb[hb - 64'd1 - p]};
            end else if (p - hb < lenb) begin
                idx = p - hb;
                r.out_byte = {carrier[7:1], mbyte[3'd7 - idx[2:0]]};
            end
            n_embed++;
        end else begin
            if (p < hb) begin
                hdr_len = {hdr_len[lsbse_pkg::LEN_W-2:0], carrier[0]};
            end else begin
                idx = p - hb;
                hl  = 64'(hdr_len);
                if (idx < hl) begin
                    accum = {accum[6:0], carrier[0]};
                    if (idx[2:0] == 3'd7 || idx == hl - 64'd1) begin
                        r.msg_valid = 1'b1;
                        r.msg_byte  = accum;
                        r.msg_last  = (idx == hl - 64'd1);
                        accum       = '0;
                    end
                end
            end
            if (p + 64'd1 >= hb) begin
                r.length_valid = 1'b1;
                r.length_bytes = hdr_len[lsbse_pkg::LEN_W-1:3];
            end
        end
        if (pos != lsbse_pkg::POS_MAX) pos = pos + 1'b1;
        n_carriers++;
        if (r.error) n_cap_err++;
        if (r.msg_valid) n_msg++;
        if (r.msg_last) n_last++;
        due_q.push_back(r);
    endfunction

    function void field(string name, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            n_mismatch++;
            $display("%0t: %s expected %0h got %0h", $time, name, e, a);
        end
    endfunction

    function void check_result(t_stego_result got);
        t_stego_result e;
        if (due_q.size() == 0) begin
            n_mismatch++;
            $display("%0t: result expected none got %0h", $time, got);
            return;
        end
        e = due_q.pop_front();
        field("out_byte", 32'(e.out_byte), 32'(got.out_byte));
        field("msg_valid", 32'(e.msg_valid), 32'(got.msg_valid));
        field("msg_byte", 32'(e.msg_byte), 32'(got.msg_byte));
        field("msg_last", 32'(e.msg_last), 32'(got.msg_last));
        field("length_valid", 32'(e.length_valid), 32'(got.length_valid));
        field("length_bytes", 32'(e.length_bytes), 32'(got.length_bytes));
        field("error", 32'(e.error), 32'(got.error));
    endfunction
endclass

module tb;
    localparam int unsigned HDR  = lsbse_pkg::HEADER_BITS;
    localparam int unsigned MB_W = lsbse_pkg::MSGB_W;
    localparam int unsigned CC_W = lsbse_pkg::CNT_W;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    lsbse_pkg::t_cfg_index  i_cfg_index = lsbse_pkg::CFG_MODE;
    logic [31:0]            i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic                   i_first = 1'b0;
    logic [7:0]             i_carrier_byte = '0;
    logic [7:0]             i_message_byte = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b1;
    logic [7:0]             o_out_byte;
    logic                   o_msg_valid;
    logic [7:0]             o_msg_byte;
    logic                   o_msg_last;
    logic                   o_length_valid;
    logic [MB_W-1:0]        o_length_bytes;
    logic                   o_error;

    stego_checker sb = new();
    int unsigned  burst_left = 0;
    int unsigned  stall_left = 0;
    int unsigned  stall_style = 0;
    logic [1:0]   stall_cyc = '0;

    lsb_stego_embed_extract dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_first        (i_first),
        .i_carrier_byte (i_carrier_byte),
        .i_message_byte (i_message_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_msg_valid    (o_msg_valid),
        .o_msg_byte     (o_msg_byte),
        .o_msg_last     (o_msg_last),
        .o_length_valid (o_length_valid),
        .o_length_bytes (o_length_bytes),
        .o_error        (o_error)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_valid && o_ready)
                sb.note_carrier(i_first, i_carrier_byte, i_message_byte);
            if (o_valid && i_ready)
                sb.check_result({o_out_byte, o_msg_valid, o_msg_byte, o_msg_last,
                                 o_length_valid, o_length_bytes, o_error});
        end
    end

    // output side: always ready, coin toss, or one cycle in four
    always @(negedge i_clk) begin
        stall_cyc <= stall_cyc + 1'b1;
        if (stall_left == 0) begin
            stall_style <= $urandom_range(0, 2);
            stall_left  <= $urandom_range(20, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_style)
            0:       i_ready <= 1'b1;
            1:       i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= (stall_cyc == 2'd0);
        endcase
    end

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_item(logic f, logic [7:0] c, logic [7:0] m);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        i_first        = f;
        i_carrier_byte = c;
        i_message_byte = m;
        i_valid        = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
        burst_left--;
    endtask

    // hold off requests until every queued result has come back
    task automatic drain();
        i_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(lsbse_pkg::t_cfg_index idx, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // unused upper bits of the narrow registers carry junk
    task automatic set_config(logic m, logic [MB_W-1:0] mb, logic [CC_W-1:0] cc);
        cfg_write(lsbse_pkg::CFG_MODE, ($urandom & 32'hFFFF_FFFE) | 32'(m));
        cfg_write(lsbse_pkg::CFG_MESSAGE_BYTES, ($urandom & 32'hE000_0000) | 32'(mb));
        cfg_write(lsbse_pkg::CFG_CARRIER_COUNT, cc);
        i_cfg_valid = 1'b0;
    endtask

    // message byte is held for its eight carriers after the header
    task automatic embed_image(int unsigned n, logic first_flag);
        logic [7:0] held;
        held = 8'($urandom);
        for (int unsigned i = 0; i < n; i++) begin
            if (i >= HDR && (i - HDR) % 8 == 0) held = 8'($urandom);
            send_item(first_flag && i == 0, 8'($urandom), held);
        end
    endtask

    // carriers whose lsbs spell a header of nbits and then the message bits
    task automatic extract_image(logic [31:0] nbits, int unsigned n, logic first_flag);
        logic       lsbs[$];
        logic [7:0] carrier;
        for (int i = int'(HDR) - 1; i >= 0; i--) lsbs.push_back(nbits[i]);
        repeat (nbits) lsbs.push_back(1'($urandom_range(0, 1)));
        for (int unsigned i = 0; i < n; i++) begin
            carrier = 8'($urandom);
            if (i < lsbs.size()) carrier[0] = lsbs[i];
            send_item(first_flag && i == 0, carrier, 8'($urandom));
        end
    endtask

    task automatic noise(int unsigned n);
        repeat (n) send_item($urandom_range(0, 15) == 0, 8'($urandom), 8'($urandom));
    endtask

    initial begin
        logic            mode;
        logic [MB_W-1:0] mb;
        logic [CC_W-1:0] cc;
        logic [63:0]     need;
        logic [31:0]     nbits;
        int unsigned     n;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: zero capacity, every carrier flags an error
        send_item(1'b1, 8'h00, 8'h00);
        send_item(1'b0, 8'hFF, 8'hFF);
        send_item(1'b0, 8'hA5, 8'h5A);
        send_item(1'b1, 8'hFF, 8'h00);
        drain();
        set_config(lsbse_pkg::MODE_EMBED, {MB_W{1'b1}}, {CC_W{1'b1}});
        send_item(1'b1, 8'h00, 8'hFF);
        send_item(1'b0, 8'hFF, 8'h00);
        send_item(1'b0, 8'h7E, 8'h81);
        drain();
        // largest message that still fits
        set_config(lsbse_pkg::MODE_EMBED, 29'h1FFF_FFFB, {CC_W{1'b1}});
        send_item(1'b1, 8'h00, 8'h00);
        send_item(1'b0, 8'hFF, 8'hFF);
        send_item(1'b0, 8'h01, 8'h00);
        send_item(1'b0, 8'hFE, 8'hFF);
        drain();
        // extract with no header yet, then a restart
        set_config(lsbse_pkg::MODE_EXTRACT, '0, '0);
        send_item(1'b1, 8'hFF, 8'h00);
        send_item(1'b0, 8'h00, 8'hFF);
        send_item(1'b0, 8'hFE, 8'h3C);
        send_item(1'b1, 8'h01, 8'hC3);
        drain();

        while (sb.n_carriers < 600) begin
            mode = 1'($urandom_range(0, 1));
            mb   = ($urandom_range(0, 9) == 0) ? MB_W'($urandom)
                                               : MB_W'($urandom_range(0, 6));
            need = 64'(mb) * 64'd8 + 64'(HDR);
            case ($urandom_range(0, 5))
                0: cc = '0;
                1: cc = {CC_W{1'b1}};
                2: cc = CC_W'(64'($urandom) % need);
                default: cc = (need + 64'd16 > 64'h0000_0000_FFFF_FFFF) ? {CC_W{1'b1}}
                                                                      : CC_W'(need + 64'($urandom_range(0, 16)));
            endcase
            set_config(mode, mb, cc);
            repeat ($urandom_range(1, 2)) begin
                if ($urandom_range(0, 9) == 0) begin
                    noise($urandom_range(5, 40));
                end else if (mode == lsbse_pkg::MODE_EMBED) begin
                    n = HDR + ((mb > 8) ? 64 : 32'(8 * mb)) + $urandom_range(0, 12);
                    if ($urandom_range(0, 6) == 0) n = $urandom_range(1, n);
                    embed_image(n, $urandom_range(0, 6) != 0);
                end else begin
                    case ($urandom_range(0, 4))
                        0:       nbits = 0;
                        1:       nbits = 8 * $urandom_range(1, 8);
                        default: nbits = $urandom_range(1, 70);
                    endcase
                    n = HDR + nbits + $urandom_range(0, 10);
                    if ($urandom_range(0, 6) == 0) n = $urandom_range(1, n);
                    extract_image(nbits, n, $urandom_range(0, 6) != 0);
                end
            end
            drain();
        end

        drain();
        $display("tb: %0d carriers streamed, %0d in embed mode, %0d over capacity",
                 sb.n_carriers, sb.n_embed, sb.n_cap_err);
        $display("tb: %0d message bytes recovered, %0d closing a message, %0d mismatches",
                 sb.n_msg, sb.n_last, sb.n_mismatch);
        if (sb.n_mismatch == 0 && sb.pending() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

// ----- lsb_stego_embed_extract.f -----
sv/lsbse_pkg.sv
sv/lsb_stego_embed_extract.sv
sv/lsbse_checker.sv
tb/sv/tb.sv
